// ----- rtl/acne_pkg.sv -----
// acne_pkg: payload structs, mode codes and fixed-point widths for the
// affine codebook nearest-center encoder. No dependencies.
`default_nettype none
package acne_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD_SHAPE = 2'd0,
    MODE_LOAD_GROUP = 2'd1,
    MODE_ENCODE     = 2'd2,
    MODE_NONE       = 2'd3
  } mode_t;

  typedef struct packed {
    logic [1:0]   mode;
    logic [3:0]   group;
    logic [7:0]   center_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic signed [15:0] gain_00;
    logic signed [15:0] gain_01;
    logic signed [15:0] gain_10;
    logic signed [15:0] gain_11;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  best_label;
    logic [32:0] best_distance;
  } out_item_t;

  localparam int unsigned CountW = 9;
  localparam int unsigned DistW  = 33;

  function automatic logic signed [15:0] sat_round(input logic signed [37:0] acc);
    logic signed [17:0] q;
    q = acc[37:20];
    if (q > 18'sd32767) return 16'sh7fff;
    if (q < -18'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/acne_ram.sv -----
// acne_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module acne_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/acne_datapath.sv -----
// acne_datapath: pipelined center forming, distance and arg-min.
// Depends on acne_pkg. One shape point per cycle, valid travels with data.
`default_nettype none
module acne_datapath
  import acne_pkg::*;
#(
  parameter int unsigned LW = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s_vld,
  input  wire logic               s_first,
  input  wire logic               s_last,
  input  wire logic [LW-1:0]      s_idx,
  input  wire logic signed [15:0] z0,
  input  wire logic signed [15:0] z1,
  input  wire logic signed [15:0] mx,
  input  wire logic signed [15:0] my,
  input  wire logic signed [15:0] g00,
  input  wire logic signed [15:0] g01,
  input  wire logic signed [15:0] g10,
  input  wire logic signed [15:0] g11,
  input  wire logic signed [15:0] px,
  input  wire logic signed [15:0] py,
  output      logic               done,
  output      logic [LW-1:0]      best_idx,
  output      logic [DistW-1:0]   best_dist
);
  // stage 1: products
  logic v1_r, f1_r, l1_r;
  logic [LW-1:0] i1_r;
  logic signed [31:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [15:0] mx1_r, my1_r;
  // stage 2: center
  logic v2_r, f2_r, l2_r;
  logic [LW-1:0] i2_r;
  logic signed [15:0] cx2_r, cy2_r;
  // stage 3: squares
  logic v3_r, f3_r, l3_r;
  logic [LW-1:0] i3_r;
  logic [33:0] sx3_r, sy3_r;
  // stage 4: arg-min
  logic [LW-1:0] bi_r;
  logic [DistW-1:0] bd_r;
  logic done_r;

  logic signed [37:0] ax, ay;
  logic signed [16:0] dx, dy;
  logic [DistW-1:0] d;
  logic take;

  assign ax = (38'(mx1_r) <<< 20) + 38'(p00_r) + 38'(p01_r) + 38'sd524288;
  assign ay = (38'(my1_r) <<< 20) + 38'(p10_r) + 38'(p11_r) + 38'sd524288;
  assign dx = 17'(px) - 17'(cx2_r);
  assign dy = 17'(py) - 17'(cy2_r);
  assign d = DistW'(sx3_r + sy3_r);
  assign take = f3_r || (d < bd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; done_r <= 1'b0;
    end else begin
      v1_r <= s_vld; v2_r <= v1_r; v3_r <= v2_r;
      done_r <= v3_r && l3_r;
    end
    f1_r <= s_first; l1_r <= s_last; i1_r <= s_idx;
    p00_r <= g00 * z0; p01_r <= g01 * z1;
    p10_r <= g10 * z0; p11_r <= g11 * z1;
    mx1_r <= mx; my1_r <= my;
    f2_r <= f1_r; l2_r <= l1_r; i2_r <= i1_r;
    cx2_r <= sat_round(ax); cy2_r <= sat_round(ay);
    f3_r <= f2_r; l3_r <= l2_r; i3_r <= i2_r;
    sx3_r <= 34'(dx * dx); sy3_r <= 34'(dy * dy);
    if (v3_r && take) begin
      bd_r <= d; bi_r <= i3_r;
    end
  end

  assign done = done_r;
  assign best_idx = bi_r;
  assign best_dist = bd_r;
endmodule
`default_nettype wire

// ----- rtl/affine_codebook_nearest_encode.sv -----
// affine_codebook_nearest_encode: top level, sequencer, tables and output register.
// Depends on acne_pkg, acne_ram, acne_datapath.
//
//  channel | ports              | handshake
//  input   | in_valid/in_ready  | valid and ready
//  output  | out_valid/out_ready| valid and ready
//  config  | cfg_we/cfg_wdata   | write enable, no wait
//
// An encode sweeps the one shape-table read port a center per cycle through a
// 4-stage datapath. Reset is synchronous; tables are undefined until written.
// The next item is taken while a result waits in the output register; a
// finished encode holds in the sequencer until that register frees,
// stalling the input.
`default_nettype none
module affine_codebook_nearest_encode
  import acne_pkg::*;
#(
  parameter int unsigned MAX_CENTERS = 256,
  parameter int unsigned GROUP_COUNT = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output      logic              in_ready,
  input  wire in_item_t          in_item,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      out_item_t         out_item,
  input  wire logic              cfg_we,
  input  wire logic [CountW-1:0] cfg_wdata
);
  localparam int unsigned LW = $clog2(MAX_CENTERS);
  localparam int unsigned GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001, ST_RUN = 3'b010, ST_WAIT = 3'b100
  } state_t;

  state_t st_r, st_nxt;
  logic [CountW-1:0] cnt_r;
  logic [LW:0] idx_r, idx_nxt, n_eff;
  logic signed [15:0] px_r, py_r;
  logic [GW-1:0] grp_r;
  logic ovld_r;
  out_item_t oitem_r;
  logic acc, enc, rd_vld_r, rd_first_r, rd_last_r;
  logic [LW-1:0] rd_idx_r;
  logic [31:0] shape_q, mean_q;
  logic [63:0] tr_q;
  logic done;
  logic dn_r, got, cap;
  logic [LW-1:0] best_idx;
  logic [DistW-1:0] best_dist;
  logic [GW-1:0] in_grp;

  assign in_grp = GW'(32'(in_item.group) % GROUP_COUNT);

  always_comb begin
    if (cnt_r == '0) n_eff = (LW+1)'(1);
    else if (32'(cnt_r) > MAX_CENTERS) n_eff = (LW+1)'(MAX_CENTERS);
    else n_eff = (LW+1)'(cnt_r);
  end

  assign in_ready = (st_r == ST_IDLE);
  assign acc = in_valid && in_ready;
  assign enc = acc && (in_item.mode == MODE_ENCODE);
  assign got = done || dn_r;
  assign cap = (st_r == ST_WAIT) && got && (!ovld_r || out_ready);

  acne_ram #(.WIDTH(32), .DEPTH(MAX_CENTERS)) u_shape (
    .clk, .we(acc && in_item.mode == MODE_LOAD_SHAPE),
    .waddr(LW'(in_item.center_index)),
    .wdata({in_item.coord_y, in_item.coord_x}),
    .raddr(idx_r[LW-1:0]), .rdata(shape_q));
  acne_ram #(.WIDTH(32), .DEPTH(GROUP_COUNT)) u_mean (
    .clk, .we(acc && in_item.mode == MODE_LOAD_GROUP), .waddr(in_grp),
    .wdata({in_item.coord_y, in_item.coord_x}), .raddr(grp_r), .rdata(mean_q));
  acne_ram #(.WIDTH(64), .DEPTH(GROUP_COUNT)) u_tr (
    .clk, .we(acc && in_item.mode == MODE_LOAD_GROUP), .waddr(in_grp),
    .wdata({in_item.gain_11, in_item.gain_10, in_item.gain_01, in_item.gain_00}),
    .raddr(grp_r), .rdata(tr_q));

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    unique case (st_r)
      ST_IDLE: if (enc) begin st_nxt = ST_RUN; idx_nxt = '0; end
      ST_RUN: begin
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt == n_eff) st_nxt = ST_WAIT;
      end
      ST_WAIT: if (cap) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; cnt_r <= CountW'(256); ovld_r <= 1'b0; rd_vld_r <= 1'b0;
      dn_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) cnt_r <= cfg_wdata;
      rd_vld_r <= (st_r == ST_RUN);
      if (cap) ovld_r <= 1'b1;
      else if (out_ready) ovld_r <= 1'b0;
      if (cap) dn_r <= 1'b0;
      else if (done) dn_r <= 1'b1;
    end
    idx_r <= idx_nxt;
    rd_idx_r <= idx_r[LW-1:0];
    rd_first_r <= (idx_r == '0);
    rd_last_r <= (idx_r + 1'b1 == n_eff);
    if (enc) begin
      px_r <= in_item.coord_x; py_r <= in_item.coord_y; grp_r <= in_grp;
    end
    if (cap) begin
      oitem_r.best_label <= 8'(best_idx);
      oitem_r.best_distance <= best_dist;
    end
  end

  // hold the finished search until the output register frees
  acne_datapath #(.LW(LW)) u_dp (
    .clk, .rst_n, .s_vld(rd_vld_r), .s_first(rd_first_r), .s_last(rd_last_r),
    .s_idx(rd_idx_r), .z0(shape_q[15:0]), .z1(shape_q[31:16]),
    .mx(mean_q[15:0]), .my(mean_q[31:16]),
    .g00(tr_q[15:0]), .g01(tr_q[31:16]), .g10(tr_q[47:32]), .g11(tr_q[63:48]),
    .px(px_r), .py(py_r), .done, .best_idx, .best_dist);

  assign out_valid = ovld_r;
  assign out_item = oitem_r;
endmodule
`default_nettype wire

// ----- rtl/acne_checker.sv -----
// acne_checker: port-level assertions for the encoder, bound to the top level.
// Depends on acne_pkg.
`default_nettype none
module acne_checker
  import acne_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item)) else $error("out held");
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.mode != MODE_ENCODE |=> in_ready)
    else $error("load blocked");
  a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.mode == MODE_ENCODE |=> !in_ready)
    else $error("encode not busy");
  a_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.mode != MODE_ENCODE && !out_valid |=> !out_valid)
    else $error("spurious result");
endmodule

bind affine_codebook_nearest_encode acne_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item);
`default_nettype wire
